// ----- design/wstm_pkg.sv -----
// shared types and constants of the wall strip texture mapper
// no dependencies; used by every module of the block

package wstm_pkg;

  // default screen and texture limits
  localparam int SCREEN_ROWS_DEF    = 1024;
  localparam int SCREEN_COLUMNS_DEF = 1024;
  localparam int TEXTURE_MAX_DEF    = 1024;

  // port widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // field widths
  localparam int COL_W   = 10;
  localparam int DIST_W  = 24;
  localparam int TEX_W   = 10;
  localparam int SIZE_W  = 11;
  localparam int SCALE_W = 32;

  // divider sizes: quotient of up to 31 bits plus one overflow step
  localparam int DIV_NUM_W = 44;
  localparam int DIV_DEN_W = 55;
  localparam int DIV_Q_W   = 31;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_HEIGHT = 6'd32;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_ROW    = 6'd12;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // reset values of the configuration registers
  localparam logic [SCALE_W-1:0] PLANE_SCALE_RST = 32'd7264768;
  localparam logic [SIZE_W-1:0]  SIZE_RST        = 11'd64;

  typedef enum logic {
    CMD_START,
    CMD_NEXT
  } cmd_kind_t;

  typedef enum logic [1:0] {
    FACE_NORTH,
    FACE_SOUTH,
    FACE_WEST,
    FACE_EAST
  } face_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANE_SCALE,
    CFG_HEIGHT_NORTH,
    CFG_HEIGHT_SOUTH,
    CFG_HEIGHT_WEST,
    CFG_HEIGHT_EAST,
    CFG_WIDTH_SOUTH,
    CFG_WIDTH_WEST
  } cfg_idx_t;

  typedef struct packed {
    logic [SCALE_W-1:0] plane_scale;
    logic [SIZE_W-1:0]  height_north;
    logic [SIZE_W-1:0]  height_south;
    logic [SIZE_W-1:0]  height_west;
    logic [SIZE_W-1:0]  height_east;
    logic [SIZE_W-1:0]  width_south;
    logic [SIZE_W-1:0]  width_west;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [COL_W-1:0]  column;
    logic [DIST_W-1:0] distance;
    face_t             face;
    logic [TEX_W-1:0]  tex_x;
  } cmd_t;

  typedef struct packed {
    logic                 go;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- design/wstm_front.sv -----
// front end: accepts requests, decodes them into commands and queues them
// depends on wstm_pkg

module wstm_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // screen_column, perp_distance, wall_face, texture_x, zero pad
  input  logic [wstm_pkg::IN_DATA_W-1:0] in_tdata,
  // command
  input  logic                           in_tuser,
  output logic                           q_valid,
  input  logic                           q_pop,
  output wstm_pkg::cmd_t                 q_data
);

  localparam int PTR_W = $clog2(wstm_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(wstm_pkg::QUEUE_DEPTH + 1);

  wstm_pkg::cmd_t   entry_r [wstm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  wstm_pkg::cmd_t   in_cmd;
  logic             push;
  logic             pop;

  always_comb begin
    in_cmd.kind     = in_tuser ? wstm_pkg::CMD_NEXT : wstm_pkg::CMD_START;
    in_cmd.column   = in_tdata[9:0];
    in_cmd.distance = in_tdata[33:10];
    in_cmd.face     = wstm_pkg::face_t'(in_tdata[35:34]);
    in_cmd.tex_x    = in_tdata[45:36];
  end

  assign in_tready = (count_r != CNT_W'(wstm_pkg::QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_data    = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- design/wstm_div.sv -----
// shared restoring divider, one quotient bit per cycle
// first step flags an oversize quotient, which then reads as all ones
// depends on wstm_pkg

module wstm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  wstm_pkg::div_req_t req,
  output wstm_pkg::div_rsp_t rsp
);

  logic [wstm_pkg::DIV_NUM_W-1:0] rem_r;
  logic [wstm_pkg::DIV_DEN_W-1:0] den_r;
  logic [wstm_pkg::DIV_Q_W-1:0]   q_r;
  logic [wstm_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           first_r;
  logic                           sat_r;
  logic                           done_r;
  logic [wstm_pkg::DIV_DEN_W:0]   diff;
  logic                           ge;

  assign diff = {{(wstm_pkg::DIV_DEN_W + 1 - wstm_pkg::DIV_NUM_W){1'b0}}, rem_r}
              - {1'b0, den_r};
  assign ge   = !diff[wstm_pkg::DIV_DEN_W];

  assign rsp.done     = done_r;
  assign rsp.quotient = sat_r ? '1 : q_r;

  always_ff @(posedge clk) begin
    if (req.go) begin
      rem_r   <= req.dividend;
      den_r   <= req.divisor;
      q_r     <= '0;
      sat_r   <= 1'b0;
      first_r <= 1'b1;
    end else if (busy_r) begin
      if (first_r) begin
        sat_r <= ge;
      end else begin
        q_r <= {q_r[wstm_pkg::DIV_Q_W-2:0], ge};
      end
      if (ge) begin
        rem_r <= diff[wstm_pkg::DIV_NUM_W-1:0];
      end
      den_r   <= den_r >> 1;
      first_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == wstm_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/wstm_back.sv -----
// back end: sequencer that sets up a column and emits one pixel per next-pixel request
// holds the strip state and the output register; depends on wstm_pkg, wstm_div

module wstm_back #(
  parameter int SCREEN_ROWS    = wstm_pkg::SCREEN_ROWS_DEF,
  parameter int SCREEN_COLUMNS = wstm_pkg::SCREEN_COLUMNS_DEF,
  parameter int TEXTURE_MAX    = wstm_pkg::TEXTURE_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wstm_pkg::cfg_t                  cfg,
  input  logic                            q_valid,
  input  wstm_pkg::cmd_t                  q_data,
  output logic                            q_pop,
  output wstm_pkg::div_req_t              div_req,
  input  wstm_pkg::div_rsp_t              div_rsp,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // pixel_column, pixel_row, texel_face, texel_row, texel_column, zero pad
  output logic [wstm_pkg::OUT_DATA_W-1:0] out_tdata,
  // last_pixel
  output logic                            out_tlast
);

  localparam int ROW_W = $clog2(SCREEN_ROWS + 1);
  localparam logic [32:0]      MID_Q9   = 33'(SCREEN_ROWS * 256);
  localparam logic [ROW_W-1:0] ROWS_LIM = ROW_W'(SCREEN_ROWS);
  localparam logic [24:0]      ROWS_25  = 25'(SCREEN_ROWS);
  localparam logic [11:0]      COLS_LIM = 12'(SCREEN_COLUMNS);
  localparam logic [10:0]      TEX_LIM  = 11'(TEXTURE_MAX);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDIV,
    S_HFIN,
    S_PNUM,
    S_PMUL,
    S_PDIV,
    S_POUT
  } state_t;

  state_t                          state_r;
  logic                            active_r;
  logic [ROW_W-1:0]                row_r;
  logic [ROW_W-1:0]                end_r;
  logic signed [31:0]              top_r;
  logic [wstm_pkg::DIV_Q_W-1:0]    height_r;
  wstm_pkg::face_t                 face_r;
  logic [wstm_pkg::TEX_W-1:0]      tex_x_r;
  logic [wstm_pkg::COL_W-1:0]      col_r;
  logic [32:0]                     num_r;
  wstm_pkg::div_req_t              div_req_r;
  logic                            out_valid_r;
  logic [wstm_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                            out_last_r;

  logic signed [32:0] top_full;
  logic [20:0]        first_sum;
  logic [ROW_W-1:0]   first_row;
  logic [33:0]        bot_sum;
  logic [ROW_W-1:0]   end_row;
  logic               strip_on;
  logic [33:0]        num_full;
  logic [10:0]        hf;
  logic [43:0]        prod;
  logic [10:0]        lim_h;
  logic [10:0]        trow;
  logic [10:0]        w;
  logic [10:0]        v;
  logic [10:0]        lim_w;
  logic [10:0]        tcol;
  logic               is_last;
  logic               out_free;
  logic               pix_emit;

  // column setup from the projected height
  always_comb begin
    top_full  = $signed(MID_Q9) - $signed({2'b00, div_rsp.quotient});
    first_sum = {1'b0, top_full[19:0]} + 21'd511;
    if (!top_full[32] && top_full != '0) begin
      first_row = ROW_W'(first_sum[20:9]);
    end else begin
      first_row = '0;
    end
    bot_sum = 34'(MID_Q9) + 34'(div_rsp.quotient) + 34'd511;
    if (bot_sum[33:9] > ROWS_25) begin
      end_row = ROWS_LIM;
    end else begin
      end_row = ROW_W'(bot_sum[33:9]);
    end
    strip_on = (first_row < end_row) && ({2'b00, col_r} < COLS_LIM);
  end

  // per-pixel texture mapping
  always_comb begin
    num_full = 34'({row_r, 9'd0}) - {{2{top_r[31]}}, top_r};
    unique case (face_r)
      wstm_pkg::FACE_NORTH: hf = cfg.height_north;
      wstm_pkg::FACE_SOUTH: hf = cfg.height_south;
      wstm_pkg::FACE_WEST:  hf = cfg.height_west;
      wstm_pkg::FACE_EAST:  hf = cfg.height_east;
    endcase
    prod  = num_r * hf;
    lim_h = (hf > TEX_LIM) ? TEX_LIM : hf;
    if (hf == '0 || height_r == '0) begin
      trow = '0;
    end else if (div_rsp.quotient > 31'(lim_h - 11'd1)) begin
      trow = lim_h - 11'd1;
    end else begin
      trow = div_rsp.quotient[10:0];
    end

    // south and west textures are mirrored
    w     = (face_r == wstm_pkg::FACE_SOUTH) ? cfg.width_south : cfg.width_west;
    v     = w - 11'd1 - {1'b0, tex_x_r};
    lim_w = (w > TEX_LIM) ? TEX_LIM : w;
    if (face_r == wstm_pkg::FACE_SOUTH || face_r == wstm_pkg::FACE_WEST) begin
      if (w == '0 || {1'b0, tex_x_r} >= w) begin
        tcol = '0;
      end else if (v > lim_w - 11'd1) begin
        tcol = lim_w - 11'd1;
      end else begin
        tcol = v;
      end
    end else if ({1'b0, tex_x_r} > TEX_LIM - 11'd1) begin
      tcol = TEX_LIM - 11'd1;
    end else begin
      tcol = {1'b0, tex_x_r};
    end

    is_last  = ({1'b0, row_r} + 1'b1) >= {1'b0, end_r};
    out_free = !out_valid_r || out_tready;
    pix_emit = (state_r == S_POUT) && out_free;
  end

  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign div_req    = div_req_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      active_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      div_req_r.go <= 1'b0;
    end else begin
      // divider kicks off on a start and after the multiply
      div_req_r.go <= ((state_r == S_IDLE) && q_valid && (q_data.kind == wstm_pkg::CMD_START))
                      || (state_r == S_PMUL);
      if (pix_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_data.kind == wstm_pkg::CMD_START) begin
              col_r              <= q_data.column;
              face_r             <= q_data.face;
              tex_x_r            <= q_data.tex_x;
              div_req_r.dividend <= 44'({cfg.plane_scale, 8'd0});
              div_req_r.divisor  <= {q_data.distance, 31'd0};
              div_req_r.steps    <= wstm_pkg::DIV_STEPS_HEIGHT;
              state_r            <= S_HDIV;
            end else if (active_r) begin
              state_r <= S_PNUM;
            end
          end
        end
        S_HDIV: begin
          if (div_rsp.done) begin
            state_r <= S_HFIN;
          end
        end
        S_HFIN: begin
          height_r <= div_rsp.quotient;
          top_r    <= top_full[31:0];
          row_r    <= first_row;
          end_r    <= end_row;
          active_r <= strip_on;
          state_r  <= S_IDLE;
        end
        S_PNUM: begin
          num_r   <= num_full[32:0];
          state_r <= S_PMUL;
        end
        S_PMUL: begin
          div_req_r.dividend <= prod;
          div_req_r.divisor  <= 55'({height_r, 12'd0});
          div_req_r.steps    <= wstm_pkg::DIV_STEPS_ROW;
          state_r            <= S_PDIV;
        end
        S_PDIV: begin
          if (div_rsp.done) begin
            state_r <= S_POUT;
          end
        end
        S_POUT: begin
          if (out_free) begin
            out_data_r  <= {6'd0, tcol[9:0], trow[9:0], face_r, 10'(row_r), col_r};
            out_last_r  <= is_last;
            row_r       <= row_r + 1'b1;
            if (is_last) begin
              active_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/wall_strip_texture_mapper.sv -----
// top level of the wall strip texture mapper: configuration registers and wiring
// depends on wstm_pkg, wstm_front, wstm_div, wstm_back
//
// usage:
//   in_*  stream carries requests. tuser = 0 starts a column (tdata holds the
//         screen column, Q16.8 distance, wall face and texture column); tuser = 1
//         asks for the next pixel of the active column.
//   out_* stream carries one pixel per next-pixel request while a column is
//         active; tlast marks the final pixel. Starts and next-pixel requests
//         with no active column give no output.
//   cfg_* writes a register; keep writes to when the block is idle (not enforced).
// operation: a start runs the 32 steps of the shared one-bit-per-cycle divider
//   computing plane_scale / distance. A pixel computes the row offset, then a
//   33x11 multiply, then 12 divider steps for the texture row. Requests are
//   taken into a two-entry queue while the back end works, so the input side
//   keeps moving until the queue fills.
// reset: clears the queue, the strip state and the output register, and
//   reloads the configuration defaults.
// stalls: a pixel waits in the output register until taken; the back end
//   holds the next pixel until that register frees up.

module wall_strip_texture_mapper #(
  parameter int SCREEN_ROWS    = wstm_pkg::SCREEN_ROWS_DEF,
  parameter int SCREEN_COLUMNS = wstm_pkg::SCREEN_COLUMNS_DEF,
  parameter int TEXTURE_MAX    = wstm_pkg::TEXTURE_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // screen_column, perp_distance, wall_face, texture_x, zero pad
  input  logic [wstm_pkg::IN_DATA_W-1:0]  in_tdata,
  // command
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // pixel_column, pixel_row, texel_face, texel_row, texel_column, zero pad
  output logic [wstm_pkg::OUT_DATA_W-1:0] out_tdata,
  // last_pixel
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [wstm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wstm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  wstm_pkg::cfg_t     cfg_r;
  logic               q_valid;
  logic               q_pop;
  wstm_pkg::cmd_t     q_data;
  wstm_pkg::div_req_t div_req;
  wstm_pkg::div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.plane_scale  <= wstm_pkg::PLANE_SCALE_RST;
      cfg_r.height_north <= wstm_pkg::SIZE_RST;
      cfg_r.height_south <= wstm_pkg::SIZE_RST;
      cfg_r.height_west  <= wstm_pkg::SIZE_RST;
      cfg_r.height_east  <= wstm_pkg::SIZE_RST;
      cfg_r.width_south  <= wstm_pkg::SIZE_RST;
      cfg_r.width_west   <= wstm_pkg::SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wstm_pkg::CFG_PLANE_SCALE:  cfg_r.plane_scale  <= cfg_wdata;
        wstm_pkg::CFG_HEIGHT_NORTH: cfg_r.height_north <= cfg_wdata[10:0];
        wstm_pkg::CFG_HEIGHT_SOUTH: cfg_r.height_south <= cfg_wdata[10:0];
        wstm_pkg::CFG_HEIGHT_WEST:  cfg_r.height_west  <= cfg_wdata[10:0];
        wstm_pkg::CFG_HEIGHT_EAST:  cfg_r.height_east  <= cfg_wdata[10:0];
        wstm_pkg::CFG_WIDTH_SOUTH:  cfg_r.width_south  <= cfg_wdata[10:0];
        wstm_pkg::CFG_WIDTH_WEST:   cfg_r.width_west   <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  wstm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data)
  );

  wstm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  wstm_back #(
    .SCREEN_ROWS    (SCREEN_ROWS),
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .TEXTURE_MAX    (TEXTURE_MAX)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
